// ===== hw/rtl/heartbeat_health_monitor_top_macros.svh =====
// Assertion helpers for the monitor controller RTL.
`ifndef HEARTBEAT_HEALTH_MONITOR_TOP_MACROS_SVH
`define HEARTBEAT_HEALTH_MONITOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define HHM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Next-cycle implication, checked outside reset.
`define HHM_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define HHM_ASSERT(lbl, clk, rst, prop, msg)
`define HHM_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

// ===== hw/rtl/hhm_pkg.sv =====
package hhm_pkg;

  // Item kinds
  localparam logic [1:0] KIND_BEAT   = 2'd0;
  localparam logic [1:0] KIND_JITTER = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_WARN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_CRIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS   = 3'd4;
  localparam int CFG_DATA_W = 32;

  // Configuration reset values
  localparam logic [31:0] RST_TIMEOUT   = 32'd800;
  localparam logic [23:0] RST_HEAP_WARN = 24'd12000;
  localparam logic [23:0] RST_HEAP_CRIT = 24'd8000;
  localparam logic [23:0] RST_NOMINAL   = 24'd100000;
  localparam logic [9:0]  RST_TICK_MS   = 10'd10;

  // Jitter error saturation and average divider size
  localparam logic [30:0] ERR_SAT   = 31'h7FFF_FFFF;
  localparam int          DIV_STEPS = 72;
  localparam int          DIV_CNT_W = 7;
  localparam int          AVG_W     = 40;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  channel;
    logic [31:0] now_ticks;
    logic [62:0] now_us;
    logic [23:0] heap_free;
    logic [23:0] heap_min_free;
  } req_t;

  typedef struct packed {
    logic        last;
    logic        healthy;
    logic        heap_low;
    logic        heap_critical;
    logic        alarm;
    logic [31:0] run_ms;
    logic [39:0] jitter_avg_q8;
    logic [30:0] jitter_peak;
    logic [31:0] jitter_samples;
    logic [31:0] chan_beats;
    logic [31:0] chan_missed;
    logic        chan_overdue;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic item_load;
    logic idx_clr;
    logic idx_inc;
    logic od_clr;
    logic hb_wr;
    logic prev_wr;
    logic j_sub;
    logic j_mag;
    logic j_ofs;
    logic j_abs;
    logic j_acc;
    logic s_mul;
    logic s_cmp;
    logic div_start;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] kind;
    logic       prev_zero;
    logic       idx_last;
    logic       cnt_zero;
    logic       div_done;
    logic       out_free;
  } sts_t;

endpackage

// ===== hw/rtl/heartbeat_health_monitor_top.sv =====
// Heartbeat, jitter and health monitor over CHANNELS heartbeat sources.
// A first jitter tick only records its time; later ticks are measured.
// Status check: the 72-step serial divider forms the jitter average when samples
// exist, then one record per cycle unless stalled.
// One item is in work at a time; req_stall is low only when the block is free.
// Synchronous active-high rst clears config to defaults and all counters.
module heartbeat_health_monitor_top import hhm_pkg::*; #(
  parameter int CHANNELS = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req_data,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  hhm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  hhm_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_data  (req_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data)
  );

endmodule

// ===== hw/rtl/hhm_div.sv =====
module hhm_div import hhm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          sum,
  input  logic [31:0]          count,
  output logic                 done,
  output logic [AVG_W-1:0]     quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [71:0]          dvd;
  logic [31:0]          den;
  logic [31:0]          rem;
  logic [AVG_W-1:0]     q;
  logic                 ovf;

  logic [32:0] trial;
  logic [32:0] trial_sub;
  logic        ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial     = {rem, dvd[71]};
    trial_sub = trial - {1'b0, den};
    ge        = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend is sum scaled by 256; quotient bits above 40 only flag overflow
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {sum, 8'h00};
      den <= count;
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      dvd <= {dvd[70:0], 1'b0};
      rem <= ge ? trial_sub[31:0] : trial[31:0];
      q   <= {q[AVG_W-2:0], ge};
      ovf <= ovf | q[AVG_W-1];
    end
  end

  assign quotient = ovf ? '1 : q;

endmodule

// ===== hw/rtl/hhm_datapath.sv =====
module hhm_datapath import hhm_pkg::*; #(
  parameter int CHANNELS = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  req_t                  req_data,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  rsp_stall,
  output logic                  rsp_valid,
  output rsp_t                  rsp_data
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration
  logic [31:0] timeout_ms;
  logic [23:0] warn_floor;
  logic [23:0] crit_floor;
  logic [23:0] nominal_period_us;
  logic [9:0]  tick_ms;

  // Channel state
  logic [31:0] beat_time    [CHANNELS];
  logic [31:0] beat_count   [CHANNELS];
  logic [31:0] miss_count   [CHANNELS];
  logic        overdue_flag [CHANNELS];

  // Jitter state
  logic [62:0] prev_us;
  logic [63:0] error_sum;
  logic [30:0] error_max;
  logic [31:0] error_count;

  // Working registers
  req_t        item;
  logic [CW-1:0] idx;
  logic        any_od;
  logic [63:0] dlt;
  logic [62:0] mag;
  logic [64:0] ofs;
  logic [30:0] err;
  logic [31:0] ms;
  logic [31:0] uptime;

  logic [AVG_W-1:0] div_q;
  logic             div_done;

  logic [4:0]    chan_ext;
  logic          chan_ok;
  logic [CW-1:0] addr;
  logic [63:0]   dneg;
  logic [64:0]   oneg;
  logic [64:0]   oabs;
  logic [31:0]   elapsed;
  logic [41:0]   ms_prod;
  logic [41:0]   up_prod;
  logic          od_now;
  logic          heap_low;
  logic          heap_crit;
  logic          healthy;

  hhm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .sum      (error_sum),
    .count    (error_count),
    .done     (div_done),
    .quotient (div_q)
  );

  // Address and arithmetic helpers
  always_comb begin
    chan_ext  = {3'b000, item.channel};
    chan_ok   = chan_ext < 5'(CHANNELS);
    addr      = cmd.hb_wr ? chan_ext[CW-1:0] : idx;
    dneg      = 64'd0 - dlt;
    oneg      = 65'd0 - ofs;
    oabs      = ofs[64] ? oneg : ofs;
    elapsed   = item.now_ticks - beat_time[addr];
    ms_prod   = 42'(elapsed) * 42'(tick_ms);
    up_prod   = 42'(item.now_ticks) * 42'(tick_ms);
    od_now    = ms > timeout_ms;
    heap_low  = (item.heap_free < warn_floor) || (item.heap_min_free < warn_floor);
    heap_crit = (item.heap_free < crit_floor) || (item.heap_min_free < crit_floor);
    healthy   = !heap_low && !any_od;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms        <= RST_TIMEOUT;
      warn_floor        <= RST_HEAP_WARN;
      crit_floor        <= RST_HEAP_CRIT;
      nominal_period_us <= RST_NOMINAL;
      tick_ms           <= RST_TICK_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT:   timeout_ms        <= cfg_data;
        CFG_HEAP_WARN: warn_floor        <= cfg_data[23:0];
        CFG_HEAP_CRIT: crit_floor        <= cfg_data[23:0];
        CFG_NOMINAL:   nominal_period_us <= cfg_data[23:0];
        CFG_TICK_MS:   tick_ms           <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Channel tables: heartbeat update and overdue check
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        beat_time[i]    <= '0;
        beat_count[i]   <= '0;
        miss_count[i]   <= '0;
        overdue_flag[i] <= 1'b0;
      end
    end else begin
      if (cmd.hb_wr && chan_ok) begin
        beat_time[addr]  <= item.now_ticks;
        beat_count[addr] <= beat_count[addr] + 32'd1;
      end
      if (cmd.s_cmp) begin
        overdue_flag[addr] <= od_now;
        if (od_now) begin
          miss_count[addr] <= miss_count[addr] + 32'd1;
        end
      end
    end
  end

  // Jitter statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_us     <= '0;
      error_sum   <= '0;
      error_max   <= '0;
      error_count <= '0;
    end else begin
      if (cmd.prev_wr) begin
        prev_us <= item.now_us;
      end
      if (cmd.j_acc) begin
        error_sum   <= error_sum + {33'd0, err};
        error_count <= error_count + 32'd1;
        if (err > error_max) begin
          error_max <= err;
        end
      end
    end
  end

  // Control-side working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      any_od    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
      if (cmd.od_clr) begin
        any_od <= 1'b0;
      end else if (cmd.s_cmp && od_now) begin
        any_od <= 1'b1;
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers: item, jitter pipeline, products, result record
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item <= req_data;
    end
    if (cmd.j_sub) begin
      dlt <= {1'b0, item.now_us} - {1'b0, prev_us};
    end
    if (cmd.j_mag) begin
      mag <= dlt[63] ? dneg[62:0] : dlt[62:0];
    end
    if (cmd.j_ofs) begin
      ofs <= dlt[63] ? ({2'b00, mag} + {41'd0, nominal_period_us})
                     : ({2'b00, mag} - {41'd0, nominal_period_us});
    end
    if (cmd.j_abs) begin
      err <= (|oabs[64:31]) ? ERR_SAT : oabs[30:0];
    end
    if (cmd.s_mul) begin
      ms     <= ms_prod[31:0];
      uptime <= up_prod[31:0];
    end
    if (cmd.emit) begin
      rsp_data.last           <= sts.idx_last;
      rsp_data.healthy        <= healthy;
      rsp_data.heap_low       <= heap_low;
      rsp_data.heap_critical  <= heap_crit;
      rsp_data.alarm          <= !healthy || heap_crit;
      rsp_data.run_ms         <= uptime;
      rsp_data.jitter_avg_q8  <= sts.cnt_zero ? '0 : div_q;
      rsp_data.jitter_peak    <= error_max;
      rsp_data.jitter_samples <= error_count;
      rsp_data.chan_beats     <= beat_count[addr];
      rsp_data.chan_missed    <= miss_count[addr];
      rsp_data.chan_overdue   <= overdue_flag[addr];
    end
  end

  // Status back to the controller
  always_comb begin
    sts.kind      = item.kind;
    sts.prev_zero = prev_us == '0;
    sts.idx_last  = idx == CW'(CHANNELS - 1);
    sts.cnt_zero  = error_count == '0;
    sts.div_done  = div_done;
    sts.out_free  = !rsp_valid || !rsp_stall;
  end

endmodule

// ===== hw/rtl/hhm_ctrl.sv =====
`include "heartbeat_health_monitor_top_macros.svh"

module hhm_ctrl import hhm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_DISPATCH = 14'b00000000000010,
    S_HB       = 14'b00000000000100,
    S_JREC     = 14'b00000000001000,
    S_JSUB     = 14'b00000000010000,
    S_JMAG     = 14'b00000000100000,
    S_JOFS     = 14'b00000001000000,
    S_JABS     = 14'b00000010000000,
    S_JACC     = 14'b00000100000000,
    S_SMUL     = 14'b00001000000000,
    S_SCMP     = 14'b00010000000000,
    S_DIV      = 14'b00100000000000,
    S_DIV_WAIT = 14'b01000000000000,
    S_EMIT     = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = state != S_IDLE;

  // Sequence one item through the datapath
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.item_load = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.idx_clr = 1'b1;
        cmd.od_clr  = 1'b1;
        case (sts.kind)
          KIND_BEAT:   state_next = S_HB;
          KIND_JITTER: state_next = sts.prev_zero ? S_JREC : S_JSUB;
          KIND_STATUS: state_next = S_SMUL;
          default:     state_next = S_IDLE;
        endcase
      end
      S_HB: begin
        cmd.hb_wr  = 1'b1;
        state_next = S_IDLE;
      end
      S_JREC: begin
        cmd.prev_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_JSUB: begin
        cmd.j_sub  = 1'b1;
        state_next = S_JMAG;
      end
      S_JMAG: begin
        cmd.j_mag  = 1'b1;
        state_next = S_JOFS;
      end
      S_JOFS: begin
        cmd.j_ofs  = 1'b1;
        state_next = S_JABS;
      end
      S_JABS: begin
        cmd.j_abs  = 1'b1;
        state_next = S_JACC;
      end
      S_JACC: begin
        cmd.j_acc   = 1'b1;
        cmd.prev_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_SMUL: begin
        cmd.s_mul  = 1'b1;
        state_next = S_SCMP;
      end
      S_SCMP: begin
        cmd.s_cmp = 1'b1;
        if (sts.idx_last) begin
          state_next = S_DIV;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SMUL;
        end
      end
      S_DIV: begin
        // No samples: the average is zero, skip the divider
        if (sts.cnt_zero) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `HHM_ASSERT(a_done_in_wait, clk, rst, sts.div_done |-> state == S_DIV_WAIT, "divider done outside wait")
  `HHM_ASSERT(a_div_has_samples, clk, rst, cmd.div_start |-> !sts.cnt_zero, "divider started with zero count")
  `HHM_ASSERT_NEXT(a_last_to_idle, clk, rst, cmd.emit && sts.idx_last, state == S_IDLE, "last record did not end report")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import hhm_pkg::*;

  localparam int CHANNELS = 3;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS = 65;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] CHAN_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Monitor configuration as the block should hold it
  logic [31:0] m_timeout;
  logic [23:0] m_warn;
  logic [23:0] m_crit;
  logic [23:0] m_nominal;
  logic [9:0]  m_tick;

  // Monitor state as the block should hold it
  logic [31:0] hb_time [CHANNELS];
  logic [31:0] hb_count [CHANNELS];
  logic [31:0] hb_miss [CHANNELS];
  logic        hb_late [CHANNELS];
  logic [63:0] tick_prev;
  logic [63:0] jit_sum;
  logic [30:0] jit_max;
  logic [31:0] jit_cnt;

  rsp_t pending_recs[$];
  rsp_t want_rec;
  int   n_err = 0;
  int   quiet = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic [31:0] sim_ticks = 32'hFFFF_F000;
  logic [62:0] sim_us = 63'd1000;

  typedef struct {
    req_t item;
    bit   known;
    rsp_t first_rec;
  } stim_row_t;

  stim_row_t plan[$];

  heartbeat_health_monitor_top #(.CHANNELS(CHANNELS)) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data(rsp_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the monitor state by one item and queue the records it causes
  task automatic predict_monitor(input req_t it);
    logic [63:0] now;
    logic [63:0] nom;
    logic [63:0] delta;
    logic [63:0] err;
    logic [71:0] avg;
    logic [31:0] ms;
    logic        low;
    logic        crit;
    logic        any_late;
    rsp_t        rec;
    now = {1'b0, it.now_us};
    nom = 64'(m_nominal);
    case (it.kind)
      KIND_BEAT: begin
        if (it.channel < CHANNELS) begin
          hb_time[it.channel] = it.now_ticks;
          hb_count[it.channel] = hb_count[it.channel] + 1;
        end
      end
      KIND_JITTER: begin
        // a zero previous time means no tick to measure against
        if (tick_prev != 0) begin
          if (now >= tick_prev) begin
            delta = now - tick_prev;
            err = (delta >= nom) ? delta - nom : nom - delta;
          end else begin
            err = (tick_prev - now) + nom;
          end
          if (err > 64'(ERR_SAT)) err = 64'(ERR_SAT);
          jit_sum = jit_sum + err;
          if (err[30:0] > jit_max) jit_max = err[30:0];
          jit_cnt = jit_cnt + 1;
        end
        tick_prev = now;
      end
      KIND_STATUS: begin
        any_late = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
          ms = (it.now_ticks - hb_time[i]) * 32'(m_tick);
          hb_late[i] = ms > m_timeout;
          if (hb_late[i]) begin
            hb_miss[i] = hb_miss[i] + 1;
            any_late = 1'b1;
          end
        end
        low = (it.heap_free < m_warn) || (it.heap_min_free < m_warn);
        crit = (it.heap_free < m_crit) || (it.heap_min_free < m_crit);
        avg = '0;
        if (jit_cnt != 0) begin
          avg = {jit_sum, 8'h00} / 72'(jit_cnt);
          if (avg > 72'hFF_FFFF_FFFF) avg = 72'hFF_FFFF_FFFF;
        end
        for (int i = 0; i < CHANNELS; i++) begin
          rec.last = (i == CHANNELS - 1);
          rec.healthy = !low && !any_late;
          rec.heap_low = low;
          rec.heap_critical = crit;
          rec.alarm = low || any_late || crit;
          rec.run_ms = it.now_ticks * 32'(m_tick);
          rec.jitter_avg_q8 = avg[39:0];
          rec.jitter_peak = jit_max;
          rec.jitter_samples = jit_cnt;
          rec.chan_beats = hb_count[i];
          rec.chan_missed = hb_miss[i];
          rec.chan_overdue = hb_late[i];
          pending_recs.push_back(rec);
        end
      end
      default: ;
    endcase
  endtask

  // Offer one item, idling first at the current rate, and hold it until taken
  task automatic push_req(input req_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= it;
    do @(posedge clk); while (req_stall);
    predict_monitor(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] t, input logic [23:0] w, input logic [23:0] c,
                            input logic [23:0] n, input logic [9:0] k);
    write_reg(CFG_TIMEOUT, t);
    write_reg(CFG_HEAP_WARN, {8'h00, w});
    write_reg(CFG_HEAP_CRIT, {8'h00, c});
    write_reg(CFG_NOMINAL, {8'h00, n});
    write_reg(CFG_TICK_MS, {22'h0, k});
    cfg_we <= 1'b0;
    m_timeout = t;
    m_warn = w;
    m_crit = c;
    m_nominal = n;
    m_tick = k;
  endtask

  // Drop valid, wait for every record, then let the block settle
  task automatic drain();
    req_valid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic stim_row_t mk_row(input logic [1:0] kind, input logic [1:0] ch,
                                       input logic [31:0] ticks, input logic [62:0] us,
                                       input logic [23:0] hf, input logic [23:0] hm);
    stim_row_t r;
    r.item.kind = kind;
    r.item.channel = ch;
    r.item.now_ticks = ticks;
    r.item.now_us = us;
    r.item.heap_free = hf;
    r.item.heap_min_free = hm;
    r.known = 1'b0;
    r.first_rec = '0;
    return r;
  endfunction

  // Mostly realistic timelines with random content, some raw noise
  task automatic run_random(input int count);
    req_t it;
    int   pick;
    repeat (count) begin
      it.kind = 2'($urandom);
      it.channel = 2'($urandom);
      it.now_ticks = $urandom;
      it.now_us = 63'({$urandom, $urandom});
      it.heap_free = 24'($urandom);
      it.heap_min_free = 24'($urandom);
      pick = $urandom_range(0, 99);
      if (pick >= 12) begin
        sim_ticks = sim_ticks + $urandom_range(0, 30);
        if (pick < 50) begin
          it.kind = KIND_BEAT;
          it.channel = 2'($urandom_range(0, CHANNELS - 1));
          it.now_ticks = sim_ticks;
        end else if (pick < 80) begin
          it.kind = KIND_JITTER;
          sim_us = sim_us + 63'(m_nominal) + 63'($urandom_range(0, 2000)) - 63'd1000;
          it.now_us = sim_us;
        end else begin
          it.kind = KIND_STATUS;
          it.now_ticks = sim_ticks;
          if (pick < 96) begin
            it.heap_free = 24'((pick[0] ? m_warn : m_crit) + $urandom_range(0, 4) - 2);
            it.heap_min_free = 24'((pick[1] ? m_warn : m_crit) + $urandom_range(0, 4) - 2);
          end
        end
      end else if (pick < 3) begin
        it.now_us = '0;
      end
      push_req(it);
    end
  endtask

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endtask

  // Stall at random and check each accepted record against the oldest expectation
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_recs.size() == 0) begin
        $error("record with no expectation waiting");
        n_err++;
      end else begin
        want_rec = pending_recs.pop_front();
        check_field("last", 64'(want_rec.last), 64'(rsp_data.last));
        check_field("healthy", 64'(want_rec.healthy), 64'(rsp_data.healthy));
        check_field("heap_low", 64'(want_rec.heap_low), 64'(rsp_data.heap_low));
        check_field("heap_critical", 64'(want_rec.heap_critical),
                    64'(rsp_data.heap_critical));
        check_field("alarm", 64'(want_rec.alarm), 64'(rsp_data.alarm));
        check_field("run_ms", 64'(want_rec.run_ms), 64'(rsp_data.run_ms));
        check_field("jitter_avg_q8", 64'(want_rec.jitter_avg_q8),
                    64'(rsp_data.jitter_avg_q8));
        check_field("jitter_peak", 64'(want_rec.jitter_peak), 64'(rsp_data.jitter_peak));
        check_field("jitter_samples", 64'(want_rec.jitter_samples),
                    64'(rsp_data.jitter_samples));
        check_field("chan_beats", 64'(want_rec.chan_beats), 64'(rsp_data.chan_beats));
        check_field("chan_missed", 64'(want_rec.chan_missed), 64'(rsp_data.chan_missed));
        check_field("chan_overdue", 64'(want_rec.chan_overdue),
                    64'(rsp_data.chan_overdue));
      end
    end
  end

  initial begin
    stim_row_t r;
    m_timeout = RST_TIMEOUT;
    m_warn = RST_HEAP_WARN;
    m_crit = RST_HEAP_CRIT;
    m_nominal = RST_NOMINAL;
    m_tick = RST_TICK_MS;
    for (int i = 0; i < CHANNELS; i++) begin
      hb_time[i] = '0;
      hb_count[i] = '0;
      hb_miss[i] = '0;
      hb_late[i] = 1'b0;
    end
    tick_prev = '0;
    jit_sum = '0;
    jit_max = '0;
    jit_cnt = '0;

    // Fresh block, plenty of heap: all healthy and all zero
    r = mk_row(KIND_STATUS, 2'd0, 32'd0, '0, 24'd20000, 24'd20000);
    r.known = 1'b1;
    r.first_rec.healthy = 1'b1;
    plan.push_back(r);
    // Empty heap: low, critical, alarm on
    r = mk_row(KIND_STATUS, 2'd0, 32'd0, '0, 24'd0, 24'hFF_FFFF);
    r.known = 1'b1;
    r.first_rec.heap_low = 1'b1;
    r.first_rec.heap_critical = 1'b1;
    r.first_rec.alarm = 1'b1;
    plan.push_back(r);
    // Tick count at its top: every channel long silent
    plan.push_back(mk_row(KIND_STATUS, 2'd0, 32'hFFFF_FFFF, '0, 24'hFF_FFFF, 24'd0));
    plan.push_back(mk_row(KIND_BEAT, 2'd0, 32'd5, '0, '0, '0));
    plan.push_back(mk_row(KIND_BEAT, 2'd1, 32'd0, '0, '0, '0));
    plan.push_back(mk_row(KIND_BEAT, 2'd2, 32'hFFFF_FFFF, '0, '0, '0));
    // Ignored: channel out of range, unused kind
    plan.push_back(mk_row(KIND_BEAT, CHAN_NONE, 32'd123, '0, '0, '0));
    plan.push_back(mk_row(KIND_UNUSED, CHAN_NONE, 32'hFFFF_FFFF, '1, 24'hFF_FFFF, 24'hFF_FFFF));
    // Jitter: zero first tick, on-time, late, backwards, saturating
    plan.push_back(mk_row(KIND_JITTER, 2'd0, '0, 63'd0, '0, '0));
    plan.push_back(mk_row(KIND_JITTER, 2'd0, '0, 63'd100000, '0, '0));
    plan.push_back(mk_row(KIND_JITTER, 2'd0, '0, 63'd200000, '0, '0));
    plan.push_back(mk_row(KIND_JITTER, 2'd0, '0, 63'd350000, '0, '0));
    plan.push_back(mk_row(KIND_JITTER, 2'd0, '0, 63'd250000, '0, '0));
    plan.push_back(mk_row(KIND_JITTER, 2'd0, '0, '1, '0, '0));
    plan.push_back(mk_row(KIND_JITTER, 2'd0, '0, 63'd1, '0, '0));
    // Heap just under each threshold, and silence right at the timeout
    plan.push_back(mk_row(KIND_STATUS, 2'd0, 32'd60, '0, 24'd11999, 24'd12000));
    plan.push_back(mk_row(KIND_STATUS, 2'd0, 32'd90, '0, 24'd12000, 24'd7999));
    plan.push_back(mk_row(KIND_STATUS, 2'd0, 32'd85, '0, 24'd12000, 24'd12000));
    plan.push_back(mk_row(KIND_BEAT, 2'd1, 32'd85, '0, '0, '0));
    plan.push_back(mk_row(KIND_STATUS, 2'd0, 32'd85, '0, 24'd8000, 24'd8000));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      push_req(plan[i].item);
      if (plan[i].known) pending_recs[pending_recs.size() - CHANNELS] = plan[i].first_rec;
    end
    drain();

    // Random phases over several settings and idling patterns
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(32'd1, 24'd0, 24'd0, 24'd1, 10'd1);
        1: set_config(32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 10'd1023);
        2: set_config(32'd800, 24'd12000, 24'd8000, 24'd100000, 10'd0);
        4: set_config(32'd500, 24'd16000, 24'd4000, 24'd50, 10'd1000);
        default: set_config($urandom_range(1, 5000), 24'($urandom_range(0, 20000)),
                            24'($urandom_range(0, 20000)), 24'($urandom_range(1, 200000)),
                            10'($urandom_range(1, 1000)));
      endcase
      case (p)
        1: begin send_idle_pct = 49; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 49; end
        3, 5: begin send_idle_pct = 8; stall_pct = 8; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      run_random(PHASE_ITEMS);
      drain();
    end

    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/hhm_pkg.sv
hw/rtl/hhm_div.sv
hw/rtl/hhm_datapath.sv
hw/rtl/hhm_ctrl.sv
hw/rtl/heartbeat_health_monitor_top.sv
bench/tb_top.sv
